### hdl/polar_performance_table_top_defines.svh
// ----------------------------------------------------------------------------
// Polar performance table: assertion macros
// Shared property shapes for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef POLAR_PERFORMANCE_TABLE_TOP_DEFINES_SVH
`define POLAR_PERFORMANCE_TABLE_TOP_DEFINES_SVH

// Condition in one cycle implies a condition in the next cycle
`define PPT_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

// Condition implies another condition in the same cycle
`define PPT_ASSERT_SAME(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

### hdl/ppt_pkg.sv
// ----------------------------------------------------------------------------
// Polar performance table package
// Operation and status codes, field widths and shared structs.
// ----------------------------------------------------------------------------
`default_nettype none

package ppt_pkg;

    localparam int MODE_W  = 3;
    localparam int SPEED_W = 10;
    localparam int RAW_W   = 12;
    localparam int ANGLE_W = 11;
    localparam int TIME_W  = 16;
    localparam int VALUE_W = 16;
    localparam int STAT_W  = 3;
    localparam int ENTRY_W = ANGLE_W + TIME_W;

    // divider operand widths for the extrapolation
    localparam int PROD_W = 27;
    localparam int NUM_W  = 28;
    localparam int DEN_W  = 12;

    localparam logic [16:0] ZERO_TIME   = 17'd36000;
    localparam logic [11:0] REACH_SPLIT = 12'd900;
    localparam logic [11:0] HALF_TURN   = 12'd1800;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR  = 3'd0,
        MODE_INSERT = 3'd1,
        MODE_TIME   = 3'd2,
        MODE_TARGET = 3'd3,
        MODE_CHECK  = 3'd4
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 3'd0,
        ST_EMPTY = 3'd1,
        ST_TIME  = 3'd2,
        ST_ANGLE = 3'd3,
        ST_FULL  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        KIND_TIME = 2'd0,
        KIND_BEAT = 2'd1,
        KIND_GYBE = 2'd2
    } kind_t;

    // register indexes on the configuration port
    localparam logic [1:0] REG_BEAT_LIMIT = 2'd0;
    localparam logic [1:0] REG_GYBE_LIMIT = 2'd1;
    localparam logic [1:0] REG_TIME_FLOOR = 2'd2;
    localparam logic [1:0] REG_TIME_CEIL  = 2'd3;

    typedef struct packed {
        logic [ANGLE_W-1:0] beat_limit;
        logic [ANGLE_W-1:0] gybe_limit;
        logic [TIME_W-1:0]  time_floor;
        logic [TIME_W-1:0]  time_ceiling;
    } cfg_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        status_t            status;
    } result_t;

endpackage

`default_nettype wire

### hdl/polar_performance_table_top.sv
// ----------------------------------------------------------------------------
// Polar performance table
// Sorted speed/angle table of sailing times with stream ports and APB setup.
// ----------------------------------------------------------------------------
// One operation is taken at a time; s_tready is high only while the engine is
// idle, and the result is held in an output register so the next operation
// can be taken while it waits. The row search steps past each row whose speed
// is below the key; each entry visited is read from the single-read entry
// memory and then checked; an insert also moves each entry above its slot up
// by one, with a read and a write per entry; a time query below the first
// angle runs the serial divider; check visits the stored entries until it
// finds a fault. The entry memory needs no clearing pass after reset.
`default_nettype none

module polar_performance_table_top #(
    parameter int MAX_ROWS            = 8,
    parameter int MAX_ENTRIES_PER_ROW = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // mode[2:0], wind_speed[12:3], wind_angle[24:13], time_value[40:25]
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,   // value[15:0], status[18:16]
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    ppt_pkg::cfg_t    cfg_reg;
    ppt_pkg::result_t eng_res;
    logic             eng_valid;
    logic             res_ready;
    logic             m_tvalid_reg;
    logic [23:0]      m_tdata_reg;
    logic             cfg_wr;

    // configuration registers
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.beat_limit   <= 11'd900;
            cfg_reg.gybe_limit   <= 11'd900;
            cfg_reg.time_floor   <= 16'd0;
            cfg_reg.time_ceiling <= 16'hFFFF;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                ppt_pkg::REG_BEAT_LIMIT: cfg_reg.beat_limit   <= pwdata[10:0];
                ppt_pkg::REG_GYBE_LIMIT: cfg_reg.gybe_limit   <= pwdata[10:0];
                ppt_pkg::REG_TIME_FLOOR: cfg_reg.time_floor   <= pwdata[15:0];
                ppt_pkg::REG_TIME_CEIL:  cfg_reg.time_ceiling <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[3:2])
            ppt_pkg::REG_BEAT_LIMIT: prdata = {21'd0, cfg_reg.beat_limit};
            ppt_pkg::REG_GYBE_LIMIT: prdata = {21'd0, cfg_reg.gybe_limit};
            ppt_pkg::REG_TIME_FLOOR: prdata = {16'd0, cfg_reg.time_floor};
            ppt_pkg::REG_TIME_CEIL:  prdata = {16'd0, cfg_reg.time_ceiling};
            default:                 prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    ppt_engine #(
        .MAX_ROWS            (MAX_ROWS),
        .MAX_ENTRIES_PER_ROW (MAX_ENTRIES_PER_ROW)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (s_tdata[2:0]),
        .in_speed  (s_tdata[12:3]),
        .in_angle  (s_tdata[24:13]),
        .in_time   (s_tdata[40:25]),
        .res_valid (eng_valid),
        .res_ready (res_ready),
        .res       (eng_res)
    );

    // output register
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (eng_valid && res_ready) begin
            m_tvalid_reg <= 1'b1;
            m_tdata_reg  <= {5'd0, eng_res.status, eng_res.value};
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `include "polar_performance_table_top_defines.svh"

    `PPT_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready, "operation accepted while busy")
    `PPT_ASSERT_NEXT(a_result_loaded, aclk, aresetn, eng_valid && res_ready, m_tvalid, "result not loaded")
    `PPT_ASSERT_SAME(a_idle_no_result, aclk, aresetn, s_tready, !eng_valid, "idle engine holds a result")
    `PPT_ASSERT_SAME(a_error_zero, aclk, aresetn, m_tvalid && m_tdata[18:16] != ppt_pkg::ST_OK, m_tdata[15:0] == 16'd0, "error with nonzero value")

endmodule

`default_nettype wire

### hdl/ppt_entry_mem.sv
// ----------------------------------------------------------------------------
// Entry memory
// Simple dual-port synchronous RAM holding angle and time of every entry.
// ----------------------------------------------------------------------------
`default_nettype none

module ppt_entry_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7,
    parameter int DW    = 27
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hdl/ppt_divider.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ppt_divider (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic [ppt_pkg::NUM_W-1:0] num,
    input  wire logic [ppt_pkg::DEN_W-1:0] den,
    output logic                          done,
    output logic      [ppt_pkg::NUM_W-1:0] quo
);

    localparam int CW = $clog2(ppt_pkg::NUM_W + 1);

    logic                        busy_reg;
    logic [CW-1:0]               cnt_reg;
    logic [ppt_pkg::NUM_W-1:0]   num_reg;
    logic [ppt_pkg::DEN_W-1:0]   den_reg;
    logic [ppt_pkg::DEN_W:0]     rem_reg;
    logic [ppt_pkg::NUM_W-1:0]   quo_reg;
    logic                        done_reg;
    logic [ppt_pkg::DEN_W+1:0]   rem_sh;
    logic [ppt_pkg::DEN_W+1:0]   rem_diff;

    // shift in the next numerator bit and trial-subtract
    assign rem_sh   = {rem_reg, num_reg[ppt_pkg::NUM_W-1]};
    assign rem_diff = rem_sh - {2'b00, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(ppt_pkg::NUM_W);
                num_reg  <= num;
                den_reg  <= den;
                rem_reg  <= '0;
                quo_reg  <= '0;
            end else if (busy_reg) begin
                num_reg <= {num_reg[ppt_pkg::NUM_W-2:0], 1'b0};
                if (!rem_diff[ppt_pkg::DEN_W+1]) begin
                    rem_reg <= rem_diff[ppt_pkg::DEN_W:0];
                    quo_reg <= {quo_reg[ppt_pkg::NUM_W-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh[ppt_pkg::DEN_W:0];
                    quo_reg <= {quo_reg[ppt_pkg::NUM_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

### hdl/ppt_engine.sv
// ----------------------------------------------------------------------------
// Table engine
// Sequencer that walks row keys and entry memory for inserts, lookups and checks.
// ----------------------------------------------------------------------------
`default_nettype none

module ppt_engine #(
    parameter int MAX_ROWS            = 8,
    parameter int MAX_ENTRIES_PER_ROW = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire ppt_pkg::cfg_t                cfg,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [ppt_pkg::MODE_W-1:0]   in_mode,
    input  wire logic [ppt_pkg::SPEED_W-1:0]  in_speed,
    input  wire logic [ppt_pkg::RAW_W-1:0]    in_angle,
    input  wire logic [ppt_pkg::TIME_W-1:0]   in_time,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output ppt_pkg::result_t                  res
);

    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int EW    = $clog2(MAX_ENTRIES_PER_ROW + 1);
    localparam int DEPTH = MAX_ROWS * MAX_ENTRIES_PER_ROW;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_ROWSCAN = 12'b0000_0000_0010,
        S_ROWPICK = 12'b0000_0000_0100,
        S_ENT_RD  = 12'b0000_0000_1000,
        S_ENT_CHK = 12'b0000_0001_0000,
        S_MUL     = 12'b0000_0010_0000,
        S_DIVST   = 12'b0000_0100_0000,
        S_DIV     = 12'b0000_1000_0000,
        S_ROWRES  = 12'b0001_0000_0000,
        S_SH_RD   = 12'b0010_0000_0000,
        S_SH_WR   = 12'b0100_0000_0000,
        S_DONE    = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;

    // operation registers
    ppt_pkg::mode_t                op_reg;
    ppt_pkg::kind_t                kind_reg;
    logic [ppt_pkg::SPEED_W-1:0]   speed_key_reg;
    logic [ppt_pkg::ANGLE_W-1:0]   angle_key_reg;
    logic [11:0]                   mag_reg;
    logic [ppt_pkg::TIME_W-1:0]    time_in_reg;

    // row directory
    logic [RW-1:0]                 total_reg;
    logic [ppt_pkg::SPEED_W-1:0]   row_speed_reg [MAX_ROWS];
    logic [EW-1:0]                 row_fill_reg  [MAX_ROWS];
    logic [RIW-1:0]                row_slot_reg  [MAX_ROWS];

    // scan state
    logic [RW-1:0]                 r_idx_reg;
    logic [RIW-1:0]                row_a_reg;
    logic [RIW-1:0]                row_b_reg;
    logic                          two_reg;
    logic                          phase_reg;
    logic [EW-1:0]                 k_reg;
    logic [EW-1:0]                 j_reg;
    logic [ppt_pkg::TIME_W-1:0]    prev_t_reg;
    logic [ppt_pkg::TIME_W-1:0]    best_t_reg;
    logic [ppt_pkg::ANGLE_W-1:0]   best_a_reg;
    logic                          beat_f_reg;
    logic                          gybe_f_reg;
    logic [ppt_pkg::VALUE_W-1:0]   row_val_reg;
    logic [ppt_pkg::VALUE_W-1:0]   first_val_reg;

    // extrapolation
    logic [ppt_pkg::TIME_W-1:0]    t0_reg;
    logic [ppt_pkg::ANGLE_W-1:0]   a0_reg;
    logic [ppt_pkg::PROD_W-1:0]    prod_reg;
    logic                          neg_reg;

    ppt_pkg::result_t              res_reg;

    // memory and divider wiring
    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic [ppt_pkg::ENTRY_W-1:0]   mem_wdata;
    logic [AW-1:0]                 mem_raddr;
    logic [ppt_pkg::ENTRY_W-1:0]   mem_rdata;
    logic                          div_start;
    logic                          div_done;
    logic [ppt_pkg::NUM_W-1:0]     div_quo;

    // decoded input
    logic [11:0]                   in_mag;
    logic [ppt_pkg::ANGLE_W-1:0]   in_key;

    // current row and entry
    logic [RIW-1:0]                cur_row;
    logic [RIW-1:0]                cur_slot;
    logic [EW-1:0]                 cur_fill;
    logic [EW-1:0]                 scan_idx;
    logic [ppt_pkg::ANGLE_W-1:0]   ent_a;
    logic [ppt_pkg::TIME_W-1:0]    ent_t;
    logic                          rows_full;
    logic                          row_exact;
    logic [RIW-1:0]                lb_idx;
    logic [ppt_pkg::VALUE_W:0]     avg_prev;
    logic [ppt_pkg::VALUE_W:0]     avg_rows;
    logic [ppt_pkg::VALUE_W-1:0]   fin_val;
    logic [16:0]                   diff_mag;
    logic [ppt_pkg::VALUE_W-1:0]   extrap_val;

    function automatic logic [AW-1:0] entry_addr(input logic [RIW-1:0] slot,
                                                  input logic [EW-1:0] idx);
        entry_addr = AW'(int'(slot) * MAX_ENTRIES_PER_ROW + int'(idx));
    endfunction

    // angle magnitude, saturated key for lookups
    assign in_mag = in_angle[ppt_pkg::RAW_W-1] ? 12'(-in_angle) : in_angle;
    assign in_key = in_mag[11] ? {ppt_pkg::ANGLE_W{1'b1}} : in_mag[ppt_pkg::ANGLE_W-1:0];

    assign lb_idx    = r_idx_reg[RIW-1:0];
    assign rows_full = (total_reg == RW'(MAX_ROWS));
    assign row_exact = (r_idx_reg < total_reg) && (row_speed_reg[lb_idx] == speed_key_reg);

    assign cur_row  = (op_reg == ppt_pkg::MODE_CHECK) ? lb_idx
                    : (phase_reg ? row_b_reg : row_a_reg);
    assign cur_slot = row_slot_reg[cur_row];
    assign cur_fill = row_fill_reg[cur_row];
    assign scan_idx = (op_reg == ppt_pkg::MODE_TARGET && kind_reg == ppt_pkg::KIND_GYBE)
                    ? (cur_fill - EW'(1) - k_reg) : k_reg;

    assign ent_a = mem_rdata[ppt_pkg::ENTRY_W-1:ppt_pkg::TIME_W];
    assign ent_t = mem_rdata[ppt_pkg::TIME_W-1:0];

    // rounded averages
    assign avg_prev = ({1'b0, prev_t_reg} + {1'b0, ent_t} + 17'd1) >> 1;
    assign avg_rows = ({1'b0, first_val_reg} + {1'b0, row_val_reg} + 17'd1) >> 1;
    assign fin_val  = two_reg ? avg_rows[ppt_pkg::VALUE_W-1:0] : row_val_reg;

    // distance of the first time from the zero-angle time
    assign diff_mag = ({1'b0, t0_reg} < ppt_pkg::ZERO_TIME)
                    ? (ppt_pkg::ZERO_TIME - {1'b0, t0_reg})
                    : ({1'b0, t0_reg} - ppt_pkg::ZERO_TIME);
    assign extrap_val = neg_reg
                      ? 16'(ppt_pkg::ZERO_TIME - div_quo[16:0])
                      : 16'(ppt_pkg::ZERO_TIME + div_quo[16:0]);

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = entry_addr(row_slot_reg[row_a_reg], j_reg);
        mem_wdata = mem_rdata;
        mem_raddr = entry_addr(cur_slot, scan_idx);
        div_start = 1'b0;
        case (state_reg)
            S_SH_RD: begin
                if (j_reg == k_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = entry_addr(row_slot_reg[row_a_reg], k_reg);
                    mem_wdata = {angle_key_reg, time_in_reg};
                end else begin
                    mem_raddr = entry_addr(row_slot_reg[row_a_reg], j_reg - EW'(1));
                end
            end
            S_SH_WR: begin
                mem_we = 1'b1;
            end
            S_DIVST: begin
                div_start = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            total_reg <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (in_valid) begin
                        op_reg        <= ppt_pkg::mode_t'(in_mode);
                        speed_key_reg <= in_speed;
                        angle_key_reg <= in_key;
                        mag_reg       <= in_mag;
                        time_in_reg   <= in_time;
                        kind_reg      <= (in_mag <= ppt_pkg::REACH_SPLIT)
                                       ? ppt_pkg::KIND_BEAT : ppt_pkg::KIND_GYBE;
                        res_reg.value  <= '0;
                        res_reg.status <= ppt_pkg::ST_OK;
                        r_idx_reg      <= '0;
                        k_reg          <= '0;
                        beat_f_reg     <= 1'b0;
                        gybe_f_reg     <= 1'b0;
                        phase_reg      <= 1'b0;
                        two_reg        <= 1'b0;
                        state_reg      <= S_DONE;
                        case (in_mode)
                            ppt_pkg::MODE_CLEAR: begin
                                total_reg <= '0;
                            end
                            ppt_pkg::MODE_INSERT: begin
                                state_reg <= S_ROWSCAN;
                            end
                            ppt_pkg::MODE_TIME: begin
                                kind_reg <= ppt_pkg::KIND_TIME;
                                if (total_reg == '0) begin
                                    res_reg.status <= ppt_pkg::ST_EMPTY;
                                end else begin
                                    state_reg <= S_ROWSCAN;
                                end
                            end
                            ppt_pkg::MODE_TARGET: begin
                                if (total_reg == '0) begin
                                    res_reg.status <= ppt_pkg::ST_EMPTY;
                                end else if (in_mag <= ppt_pkg::HALF_TURN) begin
                                    state_reg <= S_ROWSCAN;
                                end
                            end
                            ppt_pkg::MODE_CHECK: begin
                                if (total_reg == '0) begin
                                    res_reg.status <= ppt_pkg::ST_EMPTY;
                                end else begin
                                    state_reg <= S_ENT_RD;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end

                // lower bound over row speeds
                S_ROWSCAN: begin
                    if (r_idx_reg < total_reg && row_speed_reg[lb_idx] < speed_key_reg) begin
                        r_idx_reg <= r_idx_reg + RW'(1);
                    end else begin
                        state_reg <= S_ROWPICK;
                    end
                end

                // choose row(s); insert opens a new row in the directory if none has its speed
                S_ROWPICK: begin
                    k_reg      <= '0;
                    prev_t_reg <= '0;
                    best_t_reg <= '0;
                    best_a_reg <= '0;
                    state_reg  <= S_ENT_RD;
                    if (op_reg == ppt_pkg::MODE_INSERT) begin
                        row_a_reg <= lb_idx;
                        if (!row_exact) begin
                            if (rows_full) begin
                                res_reg.status <= ppt_pkg::ST_FULL;
                                state_reg      <= S_DONE;
                            end else begin
                                for (int j = MAX_ROWS - 1; j > 0; j--) begin
                                    if (RW'(j) > r_idx_reg && RW'(j) <= total_reg) begin
                                        row_speed_reg[j] <= row_speed_reg[j-1];
                                        row_fill_reg[j]  <= row_fill_reg[j-1];
                                        row_slot_reg[j]  <= row_slot_reg[j-1];
                                    end
                                end
                                row_speed_reg[lb_idx] <= speed_key_reg;
                                row_fill_reg[lb_idx]  <= '0;
                                row_slot_reg[lb_idx]  <= total_reg[RIW-1:0];
                                total_reg             <= total_reg + RW'(1);
                            end
                        end
                    end else if (row_exact || r_idx_reg == '0) begin
                        row_a_reg <= lb_idx;
                    end else if (r_idx_reg >= total_reg) begin
                        row_a_reg <= RIW'(total_reg - RW'(1));
                    end else begin
                        row_a_reg <= RIW'(r_idx_reg - RW'(1));
                        row_b_reg <= lb_idx;
                        two_reg   <= 1'b1;
                    end
                end

                // end of row or issue a read
                S_ENT_RD: begin
                    if (k_reg == cur_fill) begin
                        case (op_reg)
                            ppt_pkg::MODE_INSERT: begin
                                if (cur_fill == EW'(MAX_ENTRIES_PER_ROW)) begin
                                    res_reg.status <= ppt_pkg::ST_FULL;
                                    state_reg      <= S_DONE;
                                end else begin
                                    j_reg     <= cur_fill;
                                    state_reg <= S_SH_RD;
                                end
                            end
                            ppt_pkg::MODE_TIME: begin
                                row_val_reg <= prev_t_reg;
                                state_reg   <= S_ROWRES;
                            end
                            ppt_pkg::MODE_TARGET: begin
                                row_val_reg <= ppt_pkg::VALUE_W'(best_a_reg);
                                state_reg   <= S_ROWRES;
                            end
                            default: begin
                                // table check: end of one row
                                if (!beat_f_reg || !gybe_f_reg) begin
                                    res_reg.status <= ppt_pkg::ST_ANGLE;
                                    state_reg      <= S_DONE;
                                end else if (r_idx_reg + RW'(1) == total_reg) begin
                                    state_reg <= S_DONE;
                                end else begin
                                    r_idx_reg  <= r_idx_reg + RW'(1);
                                    k_reg      <= '0;
                                    beat_f_reg <= 1'b0;
                                    gybe_f_reg <= 1'b0;
                                end
                            end
                        endcase
                    end else begin
                        state_reg <= S_ENT_CHK;
                    end
                end

                // examine one entry
                S_ENT_CHK: begin
                    state_reg <= S_ENT_RD;
                    k_reg     <= k_reg + EW'(1);
                    case (op_reg)
                        ppt_pkg::MODE_INSERT: begin
                            if (ent_a == angle_key_reg) begin
                                state_reg <= S_DONE;
                            end else if (ent_a > angle_key_reg) begin
                                k_reg <= k_reg;
                                if (cur_fill == EW'(MAX_ENTRIES_PER_ROW)) begin
                                    res_reg.status <= ppt_pkg::ST_FULL;
                                    state_reg      <= S_DONE;
                                end else begin
                                    j_reg     <= cur_fill;
                                    state_reg <= S_SH_RD;
                                end
                            end
                        end
                        ppt_pkg::MODE_TIME: begin
                            prev_t_reg <= ent_t;
                            if (ent_a == angle_key_reg) begin
                                row_val_reg <= ent_t;
                                state_reg   <= S_ROWRES;
                            end else if (ent_a > angle_key_reg) begin
                                if (k_reg == '0) begin
                                    t0_reg    <= ent_t;
                                    a0_reg    <= ent_a;
                                    state_reg <= S_MUL;
                                end else begin
                                    row_val_reg <= avg_prev[ppt_pkg::VALUE_W-1:0];
                                    state_reg   <= S_ROWRES;
                                end
                            end
                        end
                        ppt_pkg::MODE_TARGET: begin
                            if ((kind_reg == ppt_pkg::KIND_BEAT && ent_a > cfg.beat_limit) ||
                                (kind_reg == ppt_pkg::KIND_GYBE && ent_a < cfg.gybe_limit)) begin
                                row_val_reg <= ppt_pkg::VALUE_W'(best_a_reg);
                                state_reg   <= S_ROWRES;
                            end else if (ent_t > best_t_reg) begin
                                best_t_reg <= ent_t;
                                best_a_reg <= ent_a;
                            end
                        end
                        default: begin
                            if (ent_a < cfg.beat_limit) begin
                                beat_f_reg <= 1'b1;
                            end else if (ent_a > cfg.gybe_limit) begin
                                gybe_f_reg <= 1'b1;
                            end
                            if (ent_t < cfg.time_floor || ent_t > cfg.time_ceiling) begin
                                res_reg.status <= ppt_pkg::ST_TIME;
                                state_reg      <= S_DONE;
                            end
                        end
                    endcase
                end

                // extrapolation below the first angle
                S_MUL: begin
                    prod_reg  <= {10'd0, diff_mag} * {16'd0, angle_key_reg};
                    neg_reg   <= ({1'b0, t0_reg} < ppt_pkg::ZERO_TIME);
                    state_reg <= S_DIVST;
                end
                S_DIVST: begin
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        row_val_reg <= extrap_val;
                        state_reg   <= S_ROWRES;
                    end
                end

                // one row evaluated; blend two rows if needed
                S_ROWRES: begin
                    if (two_reg && !phase_reg) begin
                        first_val_reg <= row_val_reg;
                        phase_reg     <= 1'b1;
                        k_reg         <= '0;
                        prev_t_reg    <= '0;
                        best_t_reg    <= '0;
                        best_a_reg    <= '0;
                        state_reg     <= S_ENT_RD;
                    end else begin
                        state_reg <= S_DONE;
                        if (op_reg == ppt_pkg::MODE_TIME) begin
                            res_reg.value <= fin_val;
                        end else if (kind_reg == ppt_pkg::KIND_BEAT) begin
                            res_reg.value <= (ppt_pkg::VALUE_W'(mag_reg) > fin_val) ? '0 : fin_val;
                        end else begin
                            res_reg.value <= (ppt_pkg::VALUE_W'(mag_reg) < fin_val) ? '0 : fin_val;
                        end
                    end
                end

                // open a slot at the lower bound, then place the entry
                S_SH_RD: begin
                    if (j_reg == k_reg) begin
                        row_fill_reg[row_a_reg] <= row_fill_reg[row_a_reg] + EW'(1);
                        state_reg               <= S_DONE;
                    end else begin
                        state_reg <= S_SH_WR;
                    end
                end
                S_SH_WR: begin
                    j_reg     <= j_reg - EW'(1);
                    state_reg <= S_SH_RD;
                end

                S_DONE: begin
                    if (res_ready) begin
                        state_reg <= S_IDLE;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    ppt_entry_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (ppt_pkg::ENTRY_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ppt_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     ({prod_reg, 1'b0} + ppt_pkg::NUM_W'(a0_reg)),
        .den     ({a0_reg, 1'b0}),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

endmodule

`default_nettype wire

### test/ppt_checker.sv
// ----------------------------------------------------------------------------
// Polar performance table: checker
// Watches the input, result and setup ports, keeps its own copy of the table
// and the limits, predicts each result and compares it with the block.
// ----------------------------------------------------------------------------
`default_nettype none

module ppt_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [47:0] s_tdata,   // mode[2:0], wind_speed[12:3], wind_angle[24:13], time_value[40:25]
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,   // value[15:0], status[18:16]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output int               fail_count,
    output int               pending
);

    localparam int ROWS      = 8;
    localparam int ROW_DEPTH = 16;

    // shadow of the limits and the table
    logic [ppt_pkg::ANGLE_W-1:0] beat_lim, gybe_lim;
    logic [ppt_pkg::TIME_W-1:0]  t_floor, t_ceil;
    int unsigned                 rows;
    logic [ppt_pkg::SPEED_W-1:0] spd [ROWS];
    int unsigned                 fill [ROWS];
    logic [ppt_pkg::ANGLE_W-1:0] ang [ROWS*ROW_DEPTH];
    logic [ppt_pkg::TIME_W-1:0]  tim [ROWS*ROW_DEPTH];

    ppt_pkg::result_t outcome_q [$];

    function automatic int unsigned row_search(int unsigned s);
        int unsigned r;
        r = 0;
        while (r < rows && spd[r] < s) r++;
        return r;
    endfunction

    function automatic int unsigned slot_search(int unsigned r, int unsigned a);
        int unsigned k;
        k = 0;
        while (k < fill[r] && ang[r*ROW_DEPTH+k] < a) k++;
        return k;
    endfunction

    function automatic int unsigned mean2(int unsigned a, int unsigned b);
        return (a + b + 1) >> 1;
    endfunction

    function automatic int unsigned row_time(int unsigned r, int unsigned a);
        int unsigned base, m, k;
        longint a0, t0, prod, q;
        base = r * ROW_DEPTH;
        m    = fill[r];
        k    = slot_search(r, a);
        if (k < m && ang[base+k] == a) return tim[base+k];
        if (k >= m) return tim[base+m-1];
        if (k == 0) begin
            // linear from the zero-angle time up to the first entry
            a0   = ang[base];
            t0   = tim[base];
            prod = (t0 - 36000) * longint'(a);
            if (prod >= 0) q = (2 * prod + a0) / (2 * a0);
            else           q = -((2 * (-prod) + a0) / (2 * a0));
            return (36000 + q) & 16'hFFFF;
        end
        return mean2(tim[base+k-1], tim[base+k]);
    endfunction

    function automatic int unsigned row_beat(int unsigned r);
        int unsigned base, bt, ba, k;
        base = r * ROW_DEPTH;
        bt   = 0;
        ba   = 0;
        for (k = 0; k < fill[r]; k++) begin
            if (ang[base+k] > beat_lim) break;
            if (tim[base+k] > bt) begin
                bt = tim[base+k];
                ba = ang[base+k];
            end
        end
        return ba;
    endfunction

    function automatic int unsigned row_gybe(int unsigned r);
        int unsigned base, bt, ba, k;
        base = r * ROW_DEPTH;
        bt   = 0;
        ba   = 0;
        for (k = fill[r]; k > 0; k--) begin
            if (ang[base+k-1] < gybe_lim) break;
            if (tim[base+k-1] > bt) begin
                bt = tim[base+k-1];
                ba = ang[base+k-1];
            end
        end
        return ba;
    endfunction

    function automatic int unsigned row_value(ppt_pkg::kind_t kind, int unsigned r,
                                              int unsigned a);
        if (kind == ppt_pkg::KIND_TIME) return row_time(r, a);
        if (kind == ppt_pkg::KIND_BEAT) return row_beat(r);
        return row_gybe(r);
    endfunction

    // blend across speed rows; table is known to be non-empty
    function automatic int unsigned polar_lookup(ppt_pkg::kind_t kind, int unsigned s,
                                                 int unsigned a);
        int unsigned lb;
        lb = row_search(s);
        if (lb < rows && spd[lb] == s) return row_value(kind, lb, a);
        if (lb == 0) return row_value(kind, 0, a);
        if (lb >= rows) return row_value(kind, rows - 1, a);
        return mean2(row_value(kind, lb - 1, a), row_value(kind, lb, a));
    endfunction

    function automatic ppt_pkg::status_t insert_entry(int unsigned s, int unsigned a,
                                                      int unsigned t);
        int unsigned r, base, k, j, e;
        r = row_search(s);
        if (!(r < rows && spd[r] == s)) begin
            if (rows >= ROWS) return ppt_pkg::ST_FULL;
            for (j = rows; j > r; j--) begin
                spd[j]  = spd[j-1];
                fill[j] = fill[j-1];
                for (e = 0; e < ROW_DEPTH; e++) begin
                    ang[j*ROW_DEPTH+e] = ang[(j-1)*ROW_DEPTH+e];
                    tim[j*ROW_DEPTH+e] = tim[(j-1)*ROW_DEPTH+e];
                end
            end
            spd[r]  = ppt_pkg::SPEED_W'(s);
            fill[r] = 0;
            rows++;
        end
        base = r * ROW_DEPTH;
        k    = slot_search(r, a);
        if (k < fill[r] && ang[base+k] == a) return ppt_pkg::ST_OK;
        if (fill[r] >= ROW_DEPTH) return ppt_pkg::ST_FULL;
        for (j = fill[r]; j > k; j--) begin
            ang[base+j] = ang[base+j-1];
            tim[base+j] = tim[base+j-1];
        end
        ang[base+k] = ppt_pkg::ANGLE_W'(a);
        tim[base+k] = ppt_pkg::TIME_W'(t);
        fill[r]++;
        return ppt_pkg::ST_OK;
    endfunction

    function automatic ppt_pkg::status_t check_table();
        int unsigned r, k, a, t;
        bit beat, gybe;
        if (rows == 0) return ppt_pkg::ST_EMPTY;
        for (r = 0; r < rows; r++) begin
            beat = 0;
            gybe = 0;
            for (k = 0; k < fill[r]; k++) begin
                a = ang[r*ROW_DEPTH+k];
                t = tim[r*ROW_DEPTH+k];
                if (a < beat_lim) beat = 1;
                else if (a > gybe_lim) gybe = 1;
                if (t < t_floor || t > t_ceil) return ppt_pkg::ST_TIME;
            end
            if (!beat || !gybe) return ppt_pkg::ST_ANGLE;
        end
        return ppt_pkg::ST_OK;
    endfunction

    function automatic ppt_pkg::result_t predict_op(logic [47:0] d);
        logic [ppt_pkg::MODE_W-1:0] m;
        logic [ppt_pkg::RAW_W-1:0]  raw;
        int unsigned spd_key, mag, key, tval, b, g;
        ppt_pkg::result_t res;
        m       = d[2:0];
        spd_key = d[12:3];
        raw     = d[24:13];
        tval    = d[40:25];
        mag     = raw[ppt_pkg::RAW_W-1] ? (4096 - raw) : raw;
        key     = (mag > 2047) ? 2047 : mag;
        res.value  = '0;
        res.status = ppt_pkg::ST_OK;
        case (m)
            ppt_pkg::MODE_CLEAR:  rows = 0;
            ppt_pkg::MODE_INSERT: res.status = insert_entry(spd_key, key, tval);
            ppt_pkg::MODE_TIME: begin
                if (rows == 0) res.status = ppt_pkg::ST_EMPTY;
                else res.value = 16'(polar_lookup(ppt_pkg::KIND_TIME, spd_key, key));
            end
            ppt_pkg::MODE_TARGET: begin
                if (rows == 0) begin
                    res.status = ppt_pkg::ST_EMPTY;
                end else if (mag <= ppt_pkg::REACH_SPLIT) begin
                    b = polar_lookup(ppt_pkg::KIND_BEAT, spd_key, 0);
                    res.value = (mag > b) ? 16'd0 : 16'(b);
                end else if (mag <= ppt_pkg::HALF_TURN) begin
                    g = polar_lookup(ppt_pkg::KIND_GYBE, spd_key, 0);
                    res.value = (mag < g) ? 16'd0 : 16'(g);
                end
            end
            ppt_pkg::MODE_CHECK:  res.status = check_table();
            default: ;
        endcase
        return res;
    endfunction

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge aclk) begin
        ppt_pkg::result_t want;
        if (!aresetn) begin
            beat_lim = 900;
            gybe_lim = 900;
            t_floor  = 0;
            t_ceil   = 16'hFFFF;
            rows     = 0;
            outcome_q.delete();
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    ppt_pkg::REG_BEAT_LIMIT: beat_lim = pwdata[ppt_pkg::ANGLE_W-1:0];
                    ppt_pkg::REG_GYBE_LIMIT: gybe_lim = pwdata[ppt_pkg::ANGLE_W-1:0];
                    ppt_pkg::REG_TIME_FLOOR: t_floor  = pwdata[ppt_pkg::TIME_W-1:0];
                    ppt_pkg::REG_TIME_CEIL:  t_ceil   = pwdata[ppt_pkg::TIME_W-1:0];
                    default: ;
                endcase
            end
            // result transaction against the oldest expectation
            if (m_tvalid && m_tready) begin
                if (outcome_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: value %0d status %0d",
                                 m_tdata[15:0], m_tdata[18:16]);
                end else begin
                    want = outcome_q.pop_front();
                    if (m_tdata[15:0] !== want.value || m_tdata[18:16] !== want.status) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: value exp %0d got %0d, status exp %0d got %0d",
                                     want.value, m_tdata[15:0], want.status, m_tdata[18:16]);
                    end
                end
            end
            // input transaction
            if (s_tvalid && s_tready) outcome_q.push_back(predict_op(s_tdata));
        end
        pending = outcome_q.size();
    end

endmodule

`default_nettype wire

### test/tb_polar_performance_table_top.sv
// ----------------------------------------------------------------------------
// Polar performance table: testbench top
// Drives directed and random table operations in bursts through several limit
// settings, with a stalling result side; the checker predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_polar_performance_table_top;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 175;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // mode[2:0], wind_speed[12:3], wind_angle[24:13], time_value[40:25]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // value[15:0], status[18:16]
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          cycles;
    int          burst_left;
    int          rx_style;
    int          rx_count;

    polar_performance_table_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    ppt_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .fail_count(fail_count), .pending(pending)
    );

    always begin
        aclk = 1'b0; #5;
        aclk = 1'b1; #5;
    end

    // timeout
    initial cycles = 0;
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side stall pattern in three random styles
    always @(negedge aclk) begin
        rx_count++;
        if (rx_count % 64 == 0) rx_style = $urandom_range(0, 2);
        case (rx_style)
            0:       m_tready = 1'b1;
            1:       m_tready = 1'($urandom_range(0, 1));
            default: m_tready = ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic apb_write(logic [1:0] idx, logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_limits(int beat, int gybe, int lo, int hi);
        apb_write(ppt_pkg::REG_BEAT_LIMIT, beat);
        apb_write(ppt_pkg::REG_GYBE_LIMIT, gybe);
        apb_write(ppt_pkg::REG_TIME_FLOOR, lo);
        apb_write(ppt_pkg::REG_TIME_CEIL, hi);
    endtask

    // one transaction, sender in bursts with gaps
    task automatic send_op(logic [2:0] m, int s, int a, int t);
        logic [11:0] raw;
        raw      = 12'(a);
        s_tdata  = {7'd0, t[15:0], raw, s[9:0], m};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid = 1'b0;
            if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 10)) @(negedge aclk);
            burst_left = $urandom_range(1, 20);
        end
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (400) @(negedge aclk);
    endtask

    task automatic random_op();
        int pick, s, a, t;
        logic [2:0] m;
        pick = $urandom_range(0, 299);
        if (pick < 2)        m = ppt_pkg::MODE_CLEAR;
        else if (pick < 135) m = ppt_pkg::MODE_INSERT;
        else if (pick < 210) m = ppt_pkg::MODE_TIME;
        else if (pick < 265) m = ppt_pkg::MODE_TARGET;
        else if (pick < 297) m = ppt_pkg::MODE_CHECK;
        else                 m = 3'($urandom_range(5, 7));
        pick = $urandom_range(0, 9);
        if (pick < 4)      s = 100 * $urandom_range(1, 3);
        else if (pick < 8) s = 85 * $urandom_range(0, 11) + ($urandom_range(0, 11) == 11 ? 0 : 0);
        else               s = $urandom_range(0, 1023);
        if ($urandom_range(0, 9) < 7) a = 75 * $urandom_range(0, 24);
        else                          a = $urandom_range(0, 1800);
        if ($urandom_range(0, 3) == 0) a = -a;
        if ($urandom_range(0, 3) == 0) t = $urandom_range(0, 65535);
        else                           t = $urandom_range(20000, 50000);
        if ($urandom_range(0, 30) == 0) s = 1023;
        send_op(m, s, a, t);
    endtask

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        rx_style   = 0;
        rx_count   = 0;
        burst_left = 4;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        set_limits(900, 900, 0, 65535);

        // directed: empty table, inserts, each lookup path, check, unused codes
        send_op(ppt_pkg::MODE_CLEAR, 0, 0, 0);
        send_op(ppt_pkg::MODE_CHECK, 0, 0, 0);
        send_op(ppt_pkg::MODE_TIME, 100, 450, 0);
        send_op(ppt_pkg::MODE_TARGET, 100, 450, 0);
        send_op(ppt_pkg::MODE_INSERT, 100, 450, 40000);
        send_op(ppt_pkg::MODE_INSERT, 100, 450, 1);
        send_op(ppt_pkg::MODE_INSERT, 100, -1800, 30000);
        send_op(ppt_pkg::MODE_INSERT, 300, 900, 35000);
        send_op(ppt_pkg::MODE_INSERT, 1023, 1200, 65535);
        send_op(ppt_pkg::MODE_INSERT, 0, 0, 0);
        send_op(ppt_pkg::MODE_TIME, 100, 450, 0);
        send_op(ppt_pkg::MODE_TIME, 100, 300, 0);
        send_op(ppt_pkg::MODE_TIME, 100, 600, 0);
        send_op(ppt_pkg::MODE_TIME, 100, -1800, 0);
        send_op(ppt_pkg::MODE_TIME, 200, 600, 0);
        send_op(ppt_pkg::MODE_TIME, 1023, 1800, 0);
        send_op(ppt_pkg::MODE_TIME, 0, 1, 0);
        send_op(ppt_pkg::MODE_TARGET, 100, 450, 0);
        send_op(ppt_pkg::MODE_TARGET, 100, -1500, 0);
        send_op(ppt_pkg::MODE_TARGET, 100, 1800, 0);
        send_op(ppt_pkg::MODE_TARGET, 500, 0, 0);
        send_op(ppt_pkg::MODE_CHECK, 0, 0, 0);
        send_op(3'd5, 1023, -1, 65535);
        send_op(3'd6, 0, 0, 0);
        send_op(3'd7, 0, 0, 0);
        drain();

        // random phases, limits changed while idle
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: set_limits(900, 900, 0, 65535);
                1: set_limits(0, 1800, 65535, 0);
                2: set_limits(1800, 0, 0, 65535);
                3: set_limits(450, 1350, 20000, 50000);
                4: set_limits(2047, 2047, 65535, 65535);
                default: set_limits($urandom_range(0, 1800), $urandom_range(0, 1800),
                                    $urandom_range(0, 30000), $urandom_range(30000, 65535));
            endcase
            send_op(ppt_pkg::MODE_CLEAR, 0, 0, 0);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 2 && i == 80) begin
                    s_tvalid = 1'b0;
                    while (pending != 0) @(negedge aclk);
                end
                random_op();
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
